FILE: design/spu_pkg.sv
package spu_pkg;

   localparam int COORD_W  = 32;
   localparam int WEIGHT_W = 20;
   localparam int RAND_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int IDX_W    = 8;
   localparam int OP_W     = 3;
   localparam int FIT_W    = 32;
   // Largest product magnitude is (2^32 * 2^20) >> 16 = 2^36.
   localparam int MAG_W    = 37;
   localparam int PROD_W   = MAG_W + 1;
   localparam int ACC_W    = 40;

   localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
   localparam logic [OP_W-1:0] OP_VEL   = 3'd1;
   localparam logic [OP_W-1:0] OP_POS   = 3'd2;
   localparam logic [OP_W-1:0] OP_OFFER = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;

   typedef enum logic [2:0] {
      MS_VW,
      MS_D1,
      MS_R1,
      MS_D2,
      MS_R2
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        rd;
      mul_sel_type msel;
      logic        acc_load;
      logic        acc_add;
      logic        vel_wb;
      logic        pos_wb;
      logic        load_wr;
      logic        best_rd;
      logic        step;
      logic        offer;
      logic        copy_rd;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            idx_ok;
      logic            last_coord;
      logic            copy_last;
      logic            take;
   } dp_status_type;

   typedef struct packed {
      logic                      sat;
      logic signed [COORD_W-1:0] val;
   } clamp_type;

   function automatic clamp_type clamp_coord(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      clamp_type               r;
      hi = ACC_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
      lo = -hi - ACC_W'(1);
      r.sat = 1'b0;
      r.val = COORD_W'(v);
      if (v > hi) begin
         r.sat = 1'b1;
         r.val = COORD_W'(hi);
      end else if (v < lo) begin
         r.sat = 1'b1;
         r.val = COORD_W'(lo);
      end
      return r;
   endfunction

endpackage

FILE: design/swarm_particle_update.sv
// Channel   Handshake              Payload
// request   start / busy           req_op, req_atom_index, req_coord_*, req_init_vel_*,
//                                  req_rand_*, req_fitness
// result    rsp_valid (one cycle)  rsp_out_index, rsp_out_x/y/z, rsp_best_taken,
//                                  rsp_best_fitness, rsp_saturated
// config    APB psel/penable       inertia 0x0, personal 0x4, global 0x8 (20 bits)
//
// Load, position step and best read handle the three coordinates in turn; a velocity step
// also makes five passes per coordinate through the one shared multiplier.
// An offer that wins copies the position store into the best store, one entry per cycle
// over its single write port.
// Reset is synchronous and clears the controller, the best score and the configuration registers.
// The result beat cannot be stalled; busy stays high until it has been shown.
module swarm_particle_update #(
   parameter int MAX_ATOMS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [spu_pkg::OP_W-1:0]              req_op,
   input  logic [spu_pkg::IDX_W-1:0]             req_atom_index,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_coord_y,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_coord_z,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_init_vel_x,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_init_vel_y,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_init_vel_z,
   input  logic [spu_pkg::RAND_W-1:0]            req_rand_personal,
   input  logic [spu_pkg::RAND_W-1:0]            req_rand_global,
   input  logic [spu_pkg::FIT_W-1:0]             req_fitness,
   output logic                                  rsp_valid,
   output logic [spu_pkg::IDX_W-1:0]             rsp_out_index,
   output logic signed [spu_pkg::COORD_W-1:0]    rsp_out_x,
   output logic signed [spu_pkg::COORD_W-1:0]    rsp_out_y,
   output logic signed [spu_pkg::COORD_W-1:0]    rsp_out_z,
   output logic                                  rsp_best_taken,
   output logic [spu_pkg::FIT_W-1:0]             rsp_best_fitness,
   output logic                                  rsp_saturated,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [3:0]                            paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);
   import spu_pkg::*;

   localparam logic [1:0] REG_INERTIA  = 2'd0;
   localparam logic [1:0] REG_PERSONAL = 2'd1;
   localparam logic [1:0] REG_GLOBAL   = 2'd2;

   logic [WEIGHT_W-1:0] inertia_ff, personal_ff, global_ff;
   logic                csr_wr;
   logic [1:0]          csr_idx;
   dp_cmd_type          cmd;
   dp_status_type       status;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inertia_ff  <= WEIGHT_W'(131072);
         personal_ff <= WEIGHT_W'(98053);
         global_ff   <= WEIGHT_W'(98053);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_INERTIA:  inertia_ff  <= pwdata[WEIGHT_W-1:0];
            REG_PERSONAL: personal_ff <= pwdata[WEIGHT_W-1:0];
            REG_GLOBAL:   global_ff   <= pwdata[WEIGHT_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_INERTIA:  prdata = 32'(inertia_ff);
         REG_PERSONAL: prdata = 32'(personal_ff);
         REG_GLOBAL:   prdata = 32'(global_ff);
         default:      prdata = '0;
      endcase
   end

   spu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   spu_datapath #(
      .MAX_ATOMS (MAX_ATOMS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .inertia_weight    (inertia_ff),
      .personal_weight   (personal_ff),
      .global_weight     (global_ff),
      .req_op            (req_op),
      .req_atom_index    (req_atom_index),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_init_vel_x    (req_init_vel_x),
      .req_init_vel_y    (req_init_vel_y),
      .req_init_vel_z    (req_init_vel_z),
      .req_rand_personal (req_rand_personal),
      .req_rand_global   (req_rand_global),
      .req_fitness       (req_fitness),
      .rsp_out_index     (rsp_out_index),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_best_taken    (rsp_best_taken),
      .rsp_best_fitness  (rsp_best_fitness),
      .rsp_saturated     (rsp_saturated)
   );

endmodule

FILE: design/spu_ctrl.sv
module spu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output spu_pkg::dp_cmd_type    cmd,
   input  spu_pkg::dp_status_type status
);
   import spu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_LOAD, S_RD, S_M0, S_M1, S_M2, S_M3, S_M4,
      S_VWB, S_PWB, S_BRD, S_OFFER, S_COPY, S_RSP
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.msel = MS_VW;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
            if (start) state_in = S_DISP;
         end
         S_DISP: begin
            case (status.op)
               OP_LOAD:  state_in = status.idx_ok ? S_LOAD : S_RSP;
               OP_VEL,
               OP_POS,
               OP_READ:  state_in = status.idx_ok ? S_RD : S_RSP;
               OP_OFFER: state_in = S_OFFER;
               default:  state_in = S_IDLE;
            endcase
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            cmd.step    = 1'b1;
            if (status.last_coord) state_in = S_RSP;
         end
         S_RD: begin
            cmd.rd = 1'b1;
            case (status.op)
               OP_VEL:  state_in = S_M0;
               OP_POS:  state_in = S_PWB;
               default: state_in = S_BRD;
            endcase
         end
         S_M0: begin
            cmd.msel = MS_VW;
            state_in = S_M1;
         end
         S_M1: begin
            cmd.acc_load = 1'b1;
            cmd.msel     = MS_D1;
            state_in     = S_M2;
         end
         S_M2: begin
            cmd.msel = MS_R1;
            state_in = S_M3;
         end
         S_M3: begin
            cmd.acc_add = 1'b1;
            cmd.msel    = MS_D2;
            state_in    = S_M4;
         end
         S_M4: begin
            cmd.msel = MS_R2;
            state_in = S_VWB;
         end
         S_VWB: begin
            cmd.vel_wb = 1'b1;
            cmd.step   = 1'b1;
            state_in   = status.last_coord ? S_RSP : S_RD;
         end
         S_PWB: begin
            cmd.pos_wb = 1'b1;
            cmd.step   = 1'b1;
            state_in   = status.last_coord ? S_RSP : S_RD;
         end
         S_BRD: begin
            cmd.best_rd = 1'b1;
            cmd.step    = 1'b1;
            state_in    = status.last_coord ? S_RSP : S_RD;
         end
         S_OFFER: begin
            cmd.offer = 1'b1;
            state_in  = status.take ? S_COPY : S_RSP;
         end
         S_COPY: begin
            // The last entry read here is written back during the result beat.
            cmd.copy_rd = 1'b1;
            if (status.copy_last) state_in = S_RSP;
         end
         S_RSP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: design/spu_datapath.sv
module spu_datapath #(
   parameter int MAX_ATOMS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spu_pkg::dp_cmd_type                   cmd,
   output spu_pkg::dp_status_type                status,
   input  logic [spu_pkg::WEIGHT_W-1:0]          inertia_weight,
   input  logic [spu_pkg::WEIGHT_W-1:0]          personal_weight,
   input  logic [spu_pkg::WEIGHT_W-1:0]          global_weight,
   input  logic [spu_pkg::OP_W-1:0]              req_op,
   input  logic [spu_pkg::IDX_W-1:0]             req_atom_index,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_coord_y,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_coord_z,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_init_vel_x,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_init_vel_y,
   input  logic signed [spu_pkg::COORD_W-1:0]    req_init_vel_z,
   input  logic [spu_pkg::RAND_W-1:0]            req_rand_personal,
   input  logic [spu_pkg::RAND_W-1:0]            req_rand_global,
   input  logic [spu_pkg::FIT_W-1:0]             req_fitness,
   output logic [spu_pkg::IDX_W-1:0]             rsp_out_index,
   output logic signed [spu_pkg::COORD_W-1:0]    rsp_out_x,
   output logic signed [spu_pkg::COORD_W-1:0]    rsp_out_y,
   output logic signed [spu_pkg::COORD_W-1:0]    rsp_out_z,
   output logic                                  rsp_best_taken,
   output logic [spu_pkg::FIT_W-1:0]             rsp_best_fitness,
   output logic                                  rsp_saturated
);
   import spu_pkg::*;

   localparam int DEPTH  = 3 * MAX_ATOMS;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [COORD_W-1:0] pos_mem  [DEPTH];
   logic signed [COORD_W-1:0] vel_mem  [DEPTH];
   logic signed [COORD_W-1:0] best_mem [DEPTH];

   logic [OP_W-1:0]           op_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic signed [COORD_W-1:0] coord_ff [3];
   logic signed [COORD_W-1:0] iv_ff    [3];
   logic [RAND_W-1:0]         r1_ff, r2_ff;
   logic [FIT_W-1:0]          fit_ff;
   logic [SLOT_W-1:0]         slot_ff, cp_slot_ff;
   logic [1:0]                k_ff;
   logic                      cp_vld_ff;
   logic signed [COORD_W-1:0] pos_q_ff, vel_q_ff, best_q_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [COORD_W-1:0] res_ff [3];
   logic                      sat_ff, taken_ff, have_best_ff;
   logic [FIT_W-1:0]          best_score_ff;

   logic signed [PROD_W-1:0]      mul_a;
   logic [WEIGHT_W-1:0]           mul_b;
   logic                          mul_neg;
   logic [MAG_W-1:0]              mul_mag, mul_q;
   logic [MAG_W+WEIGHT_W-1:0]     mul_full;
   logic signed [COORD_W:0]       diff_pb, diff_gb, pos_sum;
   logic signed [ACC_W-1:0]       vel_sum;
   clamp_type                     vel_new, pos_new;
   logic                          take;

   assign diff_pb = {best_q_ff[COORD_W-1], best_q_ff} - {pos_q_ff[COORD_W-1], pos_q_ff};
   assign diff_gb = {coord_ff[k_ff][COORD_W-1], coord_ff[k_ff]}
                  - {pos_q_ff[COORD_W-1], pos_q_ff};
   assign pos_sum = {pos_q_ff[COORD_W-1], pos_q_ff} + {vel_q_ff[COORD_W-1], vel_q_ff};
   assign vel_sum = acc_ff + ACC_W'(prod_ff);
   assign vel_new = clamp_coord(vel_sum);
   assign pos_new = clamp_coord(ACC_W'(pos_sum));

   // Shared unit: sign-magnitude product, truncated toward zero after the shift.
   always_comb begin
      case (cmd.msel)
         MS_VW: begin
            mul_a = PROD_W'(vel_q_ff);
            mul_b = inertia_weight;
         end
         MS_D1: begin
            mul_a = PROD_W'(diff_pb);
            mul_b = personal_weight;
         end
         MS_R1: begin
            mul_a = prod_ff;
            mul_b = WEIGHT_W'(r1_ff);
         end
         MS_D2: begin
            mul_a = PROD_W'(diff_gb);
            mul_b = global_weight;
         end
         MS_R2: begin
            mul_a = prod_ff;
            mul_b = WEIGHT_W'(r2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_neg  = mul_a[PROD_W-1];
   assign mul_mag  = MAG_W'(mul_neg ? -mul_a : mul_a);
   assign mul_full = (MAG_W+WEIGHT_W)'(mul_mag) * (MAG_W+WEIGHT_W)'(mul_b);
   assign mul_q    = MAG_W'(mul_full >> FRAC_W);
   assign prod_in  = mul_neg ? -$signed({1'b0, mul_q}) : $signed({1'b0, mul_q});

   assign take = !have_best_ff || (fit_ff < best_score_ff);

   assign status.op         = op_ff;
   assign status.idx_ok     = (int'(idx_ff) < MAX_ATOMS);
   assign status.last_coord = (k_ff == 2'd2);
   assign status.copy_last  = (slot_ff == SLOT_W'(DEPTH - 1));
   assign status.take       = take;

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         pos_mem[slot_ff] <= coord_ff[k_ff];
      end else if (cmd.pos_wb) begin
         pos_mem[slot_ff] <= pos_new.val;
      end
      if (cmd.rd || cmd.copy_rd) begin
         pos_q_ff <= pos_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         vel_mem[slot_ff] <= iv_ff[k_ff];
      end else if (cmd.vel_wb) begin
         vel_mem[slot_ff] <= vel_new.val;
      end
      if (cmd.rd) begin
         vel_q_ff <= vel_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         best_mem[slot_ff] <= coord_ff[k_ff];
      end else if (cp_vld_ff) begin
         best_mem[cp_slot_ff] <= pos_q_ff;
      end
      if (cmd.rd) begin
         best_q_ff <= best_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_vld_ff     <= 1'b0;
         have_best_ff  <= 1'b0;
         best_score_ff <= '0;
      end else begin
         cp_vld_ff <= cmd.copy_rd;
         if (cmd.offer && take) begin
            have_best_ff  <= 1'b1;
            best_score_ff <= fit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cp_slot_ff <= slot_ff;
      if (cmd.capture) begin
         op_ff       <= req_op;
         idx_ff      <= req_atom_index;
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
         iv_ff[0]    <= req_init_vel_x;
         iv_ff[1]    <= req_init_vel_y;
         iv_ff[2]    <= req_init_vel_z;
         r1_ff       <= req_rand_personal;
         r2_ff       <= req_rand_global;
         fit_ff      <= req_fitness;
         slot_ff     <= SLOT_W'(int'(req_atom_index) * 3);
         k_ff        <= 2'd0;
         res_ff[0]   <= '0;
         res_ff[1]   <= '0;
         res_ff[2]   <= '0;
         sat_ff      <= 1'b0;
         taken_ff    <= 1'b0;
      end else begin
         if (cmd.offer) begin
            taken_ff <= take;
            slot_ff  <= '0;
         end
         if (cmd.step || cmd.copy_rd) begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end
         if (cmd.step) begin
            k_ff <= k_ff + 2'd1;
         end
         if (cmd.load_wr) begin
            res_ff[k_ff] <= coord_ff[k_ff];
         end
         if (cmd.vel_wb) begin
            res_ff[k_ff] <= vel_new.val;
            sat_ff       <= sat_ff | vel_new.sat;
         end
         if (cmd.pos_wb) begin
            res_ff[k_ff] <= pos_new.val;
            sat_ff       <= sat_ff | pos_new.sat;
         end
         if (cmd.best_rd) begin
            res_ff[k_ff] <= best_q_ff;
         end
      end
      if (cmd.msel == MS_R1 || cmd.msel == MS_R2 || cmd.acc_load || cmd.acc_add
          || cmd.msel == MS_VW) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= ACC_W'(prod_ff);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign rsp_out_index    = (op_ff == OP_OFFER) ? '0 : idx_ff;
   assign rsp_out_x        = res_ff[0];
   assign rsp_out_y        = res_ff[1];
   assign rsp_out_z        = res_ff[2];
   assign rsp_best_taken   = taken_ff;
   assign rsp_best_fitness = best_score_ff;
   assign rsp_saturated    = sat_ff;

endmodule
